// File: rtl/cau_pkg.sv
// shared defaults, opcodes and control bundle for the complex arithmetic unit
`timescale 1ns / 1ps
package cau_pkg;
    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef struct packed {
        logic valid;
        logic is_div;
        logic dz;
        logic neg_r;
        logic neg_i;
        logic sat_r;
        logic sat_i;
        logic ovf;
    } t_ctl;
endpackage

// File: rtl/cau_front.sv
// operand products, sums, add/sub/mul results and divide setup
`timescale 1ns / 1ps
module cau_front #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_take,
    input  logic [1:0]                                     i_opcode,
    input  logic signed [DATA_WIDTH-1:0]                   i_a_real,
    input  logic signed [DATA_WIDTH-1:0]                   i_a_imag,
    input  logic signed [DATA_WIDTH-1:0]                   i_b_real,
    input  logic signed [DATA_WIDTH-1:0]                   i_b_imag,
    output cau_pkg::t_ctl                                  o_ctl,
    output logic [2*DATA_WIDTH-1:0]                        o_den,
    output logic [3*DATA_WIDTH+FRAC_BITS:0]                o_rem_r,
    output logic [3*DATA_WIDTH+FRAC_BITS:0]                o_rem_i,
    output logic [DATA_WIDTH-1:0]                          o_res_r,
    output logic [DATA_WIDTH-1:0]                          o_res_i
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int CW = 3*W + FRAC_BITS + 1;
    localparam logic [2*W:0] MAXP = {{(W+2){1'b0}}, {(W-1){1'b1}}};
    localparam logic [2*W:0] MAXN = MAXP + (2*W+1)'(1);
    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    // stage a
    logic                    r_a_valid;
    logic [1:0]              r_a_op;
    logic signed [2*W-1:0]   r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_br2, r_p_bi2;
    logic signed [W:0]       r_s_re, r_s_im;

    // stage b
    logic                    r_b_valid;
    logic [1:0]              r_b_op;
    logic signed [2*W:0]     r_x_re, r_x_im;
    logic [2*W-1:0]          r_b_den;
    logic signed [W:0]       r_b_s_re, r_b_s_im;

    logic signed [2*W:0]     n_x_re, n_x_im;
    logic [2*W:0]            mag_r, mag_i, m_r, m_i;
    logic [W-1:0]            mres_r, mres_i, sres_r, sres_i;
    logic                    movf_r, movf_i, sovf_r, sovf_i;
    logic [CW-1:0]           n_rem_r, n_rem_i, dlim;
    t_ctl                    n_ctl;
    logic [W-1:0]            n_res_r, n_res_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_take;
        end
        r_a_op  <= i_opcode;
        r_p_rr  <= i_a_real * i_b_real;
        r_p_ii  <= i_a_imag * i_b_imag;
        r_p_ri  <= i_a_real * i_b_imag;
        r_p_ir  <= i_a_imag * i_b_real;
        r_p_br2 <= i_b_real * i_b_real;
        r_p_bi2 <= i_b_imag * i_b_imag;
        if (i_opcode == OP_SUB) begin
            r_s_re <= (W+1)'(i_a_real) - (W+1)'(i_b_real);
            r_s_im <= (W+1)'(i_a_imag) - (W+1)'(i_b_imag);
        end else begin
            r_s_re <= (W+1)'(i_a_real) + (W+1)'(i_b_real);
            r_s_im <= (W+1)'(i_a_imag) + (W+1)'(i_b_imag);
        end
    end

    always_comb begin
        if (r_a_op == OP_DIV) begin
            n_x_re = (2*W+1)'(r_p_rr) + (2*W+1)'(r_p_ii);
            n_x_im = (2*W+1)'(r_p_ir) - (2*W+1)'(r_p_ri);
        end else begin
            n_x_re = (2*W+1)'(r_p_rr) - (2*W+1)'(r_p_ii);
            n_x_im = (2*W+1)'(r_p_ri) + (2*W+1)'(r_p_ir);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_op   <= r_a_op;
        r_x_re   <= n_x_re;
        r_x_im   <= n_x_im;
        r_b_den  <= r_p_br2[2*W-1:0] + r_p_bi2[2*W-1:0];
        r_b_s_re <= r_s_re;
        r_b_s_im <= r_s_im;
    end

    always_comb begin
        mag_r = r_x_re[2*W] ? (~r_x_re + (2*W+1)'(1)) : r_x_re;
        mag_i = r_x_im[2*W] ? (~r_x_im + (2*W+1)'(1)) : r_x_im;
        m_r   = mag_r >> FRAC_BITS;
        m_i   = mag_i >> FRAC_BITS;

        movf_r = r_x_re[2*W] ? (m_r > MAXN) : (m_r > MAXP);
        movf_i = r_x_im[2*W] ? (m_i > MAXN) : (m_i > MAXP);
        if (r_x_re[2*W]) begin
            mres_r = movf_r ? VMIN : (~m_r[W-1:0] + W'(1));
        end else begin
            mres_r = movf_r ? VMAX : m_r[W-1:0];
        end
        if (r_x_im[2*W]) begin
            mres_i = movf_i ? VMIN : (~m_i[W-1:0] + W'(1));
        end else begin
            mres_i = movf_i ? VMAX : m_i[W-1:0];
        end

        sovf_r = r_b_s_re[W] != r_b_s_re[W-1];
        sovf_i = r_b_s_im[W] != r_b_s_im[W-1];
        sres_r = sovf_r ? (r_b_s_re[W] ? VMIN : VMAX) : r_b_s_re[W-1:0];
        sres_i = sovf_i ? (r_b_s_im[W] ? VMIN : VMAX) : r_b_s_im[W-1:0];

        n_rem_r = CW'(mag_r) << FRAC_BITS;
        n_rem_i = CW'(mag_i) << FRAC_BITS;
        dlim    = CW'(r_b_den) << (W+1);

        n_ctl.valid  = r_b_valid;
        n_ctl.is_div = r_b_op == OP_DIV;
        n_ctl.dz     = r_b_den == '0;
        n_ctl.neg_r  = r_x_re[2*W];
        n_ctl.neg_i  = r_x_im[2*W];
        n_ctl.sat_r  = n_rem_r >= dlim;
        n_ctl.sat_i  = n_rem_i >= dlim;
        case (r_b_op)
            OP_MUL: begin
                n_ctl.ovf = movf_r | movf_i;
                n_res_r   = mres_r;
                n_res_i   = mres_i;
            end
            default: begin
                n_ctl.ovf = sovf_r | sovf_i;
                n_res_r   = sres_r;
                n_res_i   = sres_i;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl <= n_ctl;
        end
        o_den   <= r_b_den;
        o_rem_r <= n_rem_r;
        o_rem_i <= n_rem_i;
        o_res_r <= n_res_r;
        o_res_i <= n_res_i;
    end
endmodule

// File: rtl/cau_div_cell.sv
// one quotient bit of the pipelined restoring divider
`timescale 1ns / 1ps
module cau_div_cell #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF,
    parameter int SHIFT      = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cau_pkg::t_ctl                     i_ctl,
    input  logic [2*DATA_WIDTH-1:0]           i_den,
    input  logic [3*DATA_WIDTH+FRAC_BITS:0]   i_rem_r,
    input  logic [3*DATA_WIDTH+FRAC_BITS:0]   i_rem_i,
    input  logic [DATA_WIDTH:0]               i_q_r,
    input  logic [DATA_WIDTH:0]               i_q_i,
    input  logic [DATA_WIDTH-1:0]             i_res_r,
    input  logic [DATA_WIDTH-1:0]             i_res_i,
    output cau_pkg::t_ctl                     o_ctl,
    output logic [2*DATA_WIDTH-1:0]           o_den,
    output logic [3*DATA_WIDTH+FRAC_BITS:0]   o_rem_r,
    output logic [3*DATA_WIDTH+FRAC_BITS:0]   o_rem_i,
    output logic [DATA_WIDTH:0]               o_q_r,
    output logic [DATA_WIDTH:0]               o_q_i,
    output logic [DATA_WIDTH-1:0]             o_res_r,
    output logic [DATA_WIDTH-1:0]             o_res_i
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int CW = 3*W + FRAC_BITS + 1;

    logic [CW-1:0] dsh;
    logic [CW:0]   diff_r, diff_i;

    assign dsh    = CW'(i_den) << SHIFT;
    assign diff_r = {1'b0, i_rem_r} - {1'b0, dsh};
    assign diff_i = {1'b0, i_rem_i} - {1'b0, dsh};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl <= i_ctl;
        end
        o_den   <= i_den;
        o_rem_r <= diff_r[CW] ? i_rem_r : diff_r[CW-1:0];
        o_rem_i <= diff_i[CW] ? i_rem_i : diff_i[CW-1:0];
        o_q_r   <= {i_q_r[W-1:0], ~diff_r[CW]};
        o_q_i   <= {i_q_i[W-1:0], ~diff_i[CW]};
        o_res_r <= i_res_r;
        o_res_i <= i_res_i;
    end
endmodule

// File: rtl/complex_arith_unit_top.sv
// complex add, subtract, multiply and divide unit, fully pipelined
`timescale 1ns / 1ps
//  channel   signals                                         transfer when
//  command   start, busy, i_opcode, i_a_*, i_b_*             start && !busy
//  result    o_valid, o_res_*, o_overflow, o_div_by_zero     o_valid
//
//  one transfer per cycle; busy stays low
//  stages a, b, front output, DATA_WIDTH+1 divider cells, output register
//  synchronous active-low reset clears all valid flags in the pipeline
//  results show for one cycle and cannot be held off
module complex_arith_unit_top #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_opcode,
    input  logic signed [DATA_WIDTH-1:0]  i_a_real,
    input  logic signed [DATA_WIDTH-1:0]  i_a_imag,
    input  logic signed [DATA_WIDTH-1:0]  i_b_real,
    input  logic signed [DATA_WIDTH-1:0]  i_b_imag,
    output logic                          o_valid,
    output logic signed [DATA_WIDTH-1:0]  o_res_real,
    output logic signed [DATA_WIDTH-1:0]  o_res_imag,
    output logic                          o_overflow,
    output logic                          o_div_by_zero
);
    import cau_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int CW  = 3*W + FRAC_BITS + 1;
    localparam int N   = W + 1;
    localparam int LAT = W + 5;
    localparam logic [W:0]   QMAXP = {2'b00, {(W-1){1'b1}}};
    localparam logic [W:0]   QMAXN = {2'b01, {(W-1){1'b0}}};
    localparam logic [W-1:0] VMAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN  = {1'b1, {(W-1){1'b0}}};

    t_ctl          c_ctl   [N+1];
    logic [2*W-1:0] c_den  [N+1];
    logic [CW-1:0] c_rem_r [N+1];
    logic [CW-1:0] c_rem_i [N+1];
    logic [W:0]    c_q_r   [N+1];
    logic [W:0]    c_q_i   [N+1];
    logic [W-1:0]  c_res_r [N+1];
    logic [W-1:0]  c_res_i [N+1];

    assign busy     = 1'b0;
    assign c_q_r[0] = '0;
    assign c_q_i[0] = '0;

    cau_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (start && !busy),
        .i_opcode (i_opcode),
        .i_a_real (i_a_real),
        .i_a_imag (i_a_imag),
        .i_b_real (i_b_real),
        .i_b_imag (i_b_imag),
        .o_ctl    (c_ctl[0]),
        .o_den    (c_den[0]),
        .o_rem_r  (c_rem_r[0]),
        .o_rem_i  (c_rem_i[0]),
        .o_res_r  (c_res_r[0]),
        .o_res_i  (c_res_i[0])
    );

    for (genvar k = 0; k < N; k++) begin : g_cell
        cau_div_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS),
            .SHIFT      (W - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (c_ctl[k]),
            .i_den   (c_den[k]),
            .i_rem_r (c_rem_r[k]),
            .i_rem_i (c_rem_i[k]),
            .i_q_r   (c_q_r[k]),
            .i_q_i   (c_q_i[k]),
            .i_res_r (c_res_r[k]),
            .i_res_i (c_res_i[k]),
            .o_ctl   (c_ctl[k+1]),
            .o_den   (c_den[k+1]),
            .o_rem_r (c_rem_r[k+1]),
            .o_rem_i (c_rem_i[k+1]),
            .o_q_r   (c_q_r[k+1]),
            .o_q_i   (c_q_i[k+1]),
            .o_res_r (c_res_r[k+1]),
            .o_res_i (c_res_i[k+1])
        );
    end

    t_ctl         t;
    logic         dovf_r, dovf_i;
    logic [W-1:0] dres_r, dres_i;
    logic [W-1:0] n_res_r, n_res_i;
    logic         n_ovf, n_dz;

    always_comb begin
        t = c_ctl[N];
        if (t.neg_r) begin
            dovf_r = t.sat_r || (c_q_r[N] > QMAXN);
            dres_r = dovf_r ? VMIN : (~c_q_r[N][W-1:0] + W'(1));
        end else begin
            dovf_r = t.sat_r || (c_q_r[N] > QMAXP);
            dres_r = dovf_r ? VMAX : c_q_r[N][W-1:0];
        end
        if (t.neg_i) begin
            dovf_i = t.sat_i || (c_q_i[N] > QMAXN);
            dres_i = dovf_i ? VMIN : (~c_q_i[N][W-1:0] + W'(1));
        end else begin
            dovf_i = t.sat_i || (c_q_i[N] > QMAXP);
            dres_i = dovf_i ? VMAX : c_q_i[N][W-1:0];
        end
        if (!t.is_div) begin
            n_res_r = c_res_r[N];
            n_res_i = c_res_i[N];
            n_ovf   = t.ovf;
            n_dz    = 1'b0;
        end else if (t.dz) begin
            n_res_r = '0;
            n_res_i = '0;
            n_ovf   = 1'b0;
            n_dz    = 1'b1;
        end else begin
            n_res_r = dres_r;
            n_res_i = dres_i;
            n_ovf   = dovf_r | dovf_i;
            n_dz    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= t.valid;
        end
        o_res_real    <= n_res_r;
        o_res_imag    <= n_res_i;
        o_overflow    <= n_ovf;
        o_div_by_zero <= n_dz;
    end

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_by_zero |-> o_res_real == '0 && o_res_imag == '0 && !o_overflow)
        else $error("divide by zero result not cleared");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without matching command transfer");

    a_ovf_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> o_res_real == VMAX || o_res_real == VMIN ||
                                  o_res_imag == VMAX || o_res_imag == VMIN)
        else $error("overflow flagged without a clamped part");
endmodule
